@@ rtl/ffha_pkg.sv @@
package ffha_pkg;

   // table geometry and allocator constants
   localparam int MAX_CHUNKS   = 64;
   localparam int HEADER_BYTES = 13;
   localparam int SPLIT_SLACK  = 16;
   localparam int ADDR_W       = 32;
   localparam int SIZE_W       = ADDR_W + 1;
   localparam int CNT_W        = $clog2(MAX_CHUNKS + 1);

   localparam logic [ADDR_W-1:0] HDR_ADDR   = ADDR_W'(HEADER_BYTES);
   localparam logic [ADDR_W-1:0] WORD_MASK  = 32'hFFFF_FFFC;
   localparam logic [ADDR_W-1:0] PAGE_MASK  = 32'hFFFF_F000;
   localparam logic [ADDR_W-1:0] PAGE_BYTES = 32'd4096;
   localparam logic [ADDR_W-1:0] WORD_BYTES = 32'd4;

   // result status codes
   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_OOM     = 2'd1;
   localparam logic [1:0] STATUS_IGNORED = 2'd2;

   // request kinds
   localparam logic REQ_ALLOC   = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   // configuration register indexes
   localparam logic [1:0] REG_HEAP_MODE    = 2'd0;
   localparam logic [1:0] REG_REGION_BASE  = 2'd1;
   localparam logic [1:0] REG_REGION_BYTES = 2'd2;
   localparam logic [1:0] REG_BOOT_START   = 2'd3;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] bytes;
      logic              free;
      logic              valid;
   } entry_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INIT,
      CELL_LOAD,
      CELL_STEP,
      CELL_TAKE,
      CELL_FREE,
      CELL_MERGE
   } cell_op_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      cell_op_type       op;
      logic [SIZE_W-1:0] size;
      logic              split_ok;
      logic              split;
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] first_bytes;
      logic [ADDR_W-1:0] rel_addr;
   } cell_cmd_type;

   // per-cell flags back to the sequencer
   typedef struct packed {
      logic              cur;
      logic              cur_valid;
      logic              alloc_hit;
      logic              split;
      logic              rel_hit;
      logic              can_merge;
      logic              right_valid;
      logic [ADDR_W-1:0] hit_addr;
   } cell_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_REL,
      ST_MSTART,
      ST_MERGE,
      ST_FINISH
   } state_type;

endpackage

@@ rtl/ffha_cell.sv @@
module ffha_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  is_head,
   input  ffha_pkg::cell_cmd_type cmd,
   input  logic                  left_mark,
   input  ffha_pkg::entry_type   left_pass,
   input  logic                  right_mark,
   input  ffha_pkg::entry_type   right_ent,
   output logic                  mark,
   output ffha_pkg::entry_type   ent,
   output ffha_pkg::entry_type   pass,
   output ffha_pkg::cell_stat_type stat
);
   import ffha_pkg::*;

   entry_type         ent_ff, ent_in;
   logic              mark_ff, mark_in;
   logic              cur, fits, split_here;
   logic [ADDR_W-1:0] pay_addr;

   // cursor sits at the last visited cell
   assign cur      = mark_ff & ~right_mark;
   assign pay_addr = ent_ff.start + HDR_ADDR;
   assign fits     = {1'b0, ent_ff.bytes} >= cmd.size;
   assign split_here = cmd.split_ok &&
      ({2'b00, ent_ff.bytes} > ({1'b0, cmd.size} + (SIZE_W+1)'(HEADER_BYTES + SPLIT_SLACK)));

   // status flags
   always_comb begin
      stat.cur         = cur;
      stat.cur_valid   = cur & ent_ff.valid;
      stat.alloc_hit   = cur & ent_ff.valid & ent_ff.free & fits;
      stat.split       = cur & ent_ff.valid & ent_ff.free & fits & split_here;
      stat.rel_hit     = cur & ent_ff.valid & (pay_addr == cmd.rel_addr);
      stat.can_merge   = cur & ent_ff.valid & ent_ff.free & right_ent.valid & right_ent.free;
      stat.right_valid = cur & right_ent.valid;
      stat.hit_addr    = (cur & ent_ff.valid) ? pay_addr : '0;
   end

   // entry handed right on an insert: the split-off tail or this entry
   always_comb begin
      pass = ent_ff;
      if (cur && split_here) begin
         pass.start = pay_addr + cmd.size[ADDR_W-1:0];
         pass.bytes = ent_ff.bytes - cmd.size[ADDR_W-1:0] - HDR_ADDR;
         pass.free  = 1'b1;
         pass.valid = 1'b1;
      end
   end

   // next entry and cursor mark
   always_comb begin
      ent_in  = ent_ff;
      mark_in = mark_ff;
      case (cmd.op)
         CELL_INIT: begin
            mark_in = 1'b0;
            if (is_head) begin
               ent_in.start = cmd.base;
               ent_in.bytes = cmd.first_bytes;
               ent_in.free  = 1'b1;
               ent_in.valid = 1'b1;
            end else begin
               ent_in = '0;
            end
         end
         CELL_LOAD: mark_in = is_head;
         CELL_STEP: mark_in = left_mark;
         CELL_TAKE: begin
            if (cur) begin
               if (split_here) ent_in.bytes = cmd.size[ADDR_W-1:0];
               ent_in.free = 1'b0;
            end else if (!mark_ff && cmd.split) begin
               ent_in = left_pass;
            end
         end
         CELL_FREE: begin
            if (cur) ent_in.free = 1'b1;
         end
         CELL_MERGE: begin
            if (cur) begin
               ent_in.bytes = ent_ff.bytes + HDR_ADDR + right_ent.bytes;
            end else if (!mark_ff) begin
               ent_in = right_ent;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.start <= '0;
         ent_ff.bytes <= '0;
         ent_ff.free  <= is_head;
         ent_ff.valid <= is_head;
         mark_ff      <= 1'b0;
      end else begin
         ent_ff  <= ent_in;
         mark_ff <= mark_in;
      end
   end

   assign mark = mark_ff;
   assign ent  = ent_ff;

endmodule

@@ rtl/first_fit_heap_allocator_top.sv @@
// channel | dir | handshake           | payload
// req     | in  | req_tvalid/tready   | tuser: req_type; tdata: request_bytes, page_align,
//         |     |                     |        release_address
// rsp     | out | rsp_tvalid/tready   | tdata: result_address, status
// csr     | in  | csr_valid/ready     | csr_index, csr_data
// Boot-mode requests and releases of address zero go straight from idle to the finish state.
// Heap allocation walks the chunk row one cell per cycle until a free chunk fits or the row ends.
// A release walks to its chunk and frees it, then sweeps the row again from the head,
// stepping one cell on or merging the cursor chunk with its free right neighbour.
// Reset is synchronous; the table holds one free chunk at region base after reset.
// A pending result in the output register stalls only the final step.
module first_fit_heap_allocator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // [31:0] request_bytes, [32] page_align,
                                   // [64:33] release_address, rest zero
   input  logic        req_tuser,  // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // [31:0] result_address, [33:32] status, rest zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import ffha_pkg::*;

   state_type state_ff, state_in;

   logic              heap_mode_ff;
   logic [ADDR_W-1:0] region_base_ff, region_bytes_ff, boot_start_ff, bump_ff, bump_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [ADDR_W-1:0] rel_ff;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic              rsp_valid_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic [1:0]        rsp_status_ff;

   logic              req_fire, csr_fire, rsp_load;
   logic              in_kind, in_align;
   logic [ADDR_W-1:0] in_bytes, in_rel;
   logic [ADDR_W-1:0] bump_pg, bump_al, boot_round;
   logic [SIZE_W-1:0] size_raw;

   cell_cmd_type      cmd;
   cell_stat_type     stat [MAX_CHUNKS];
   entry_type         ents [MAX_CHUNKS];
   entry_type         passes [MAX_CHUNKS];
   logic [MAX_CHUNKS-1:0] marks, cur_vec;
   logic              any_alloc, any_split, any_rel, any_merge, any_cur_valid, any_right;
   logic              at_tail;
   logic [ADDR_W-1:0] hit_addr;

   assign in_kind  = req_tuser;
   assign in_bytes = req_tdata[31:0];
   assign in_align = req_tdata[32];
   assign in_rel   = req_tdata[64:33];

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign csr_fire   = csr_valid & csr_ready;
   assign rsp_load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   // bump pointer arithmetic
   assign bump_pg = (in_align && (bump_ff[11:0] != 12'd0)) ?
                    (bump_ff & PAGE_MASK) + PAGE_BYTES : bump_ff;
   assign bump_al = (bump_pg[1:0] != 2'd0) ? (bump_pg & WORD_MASK) + WORD_BYTES : bump_pg;
   assign boot_round = (csr_data[1:0] != 2'd0) ? (csr_data & WORD_MASK) + WORD_BYTES
                                                : csr_data;
   assign size_raw = (in_bytes[1:0] != 2'd0) ?
                     ({1'b0, in_bytes & WORD_MASK} + SIZE_W'(4)) : {1'b0, in_bytes};

   // collapse cell flags
   always_comb begin
      any_alloc = 1'b0; any_split = 1'b0; any_rel = 1'b0; any_merge = 1'b0;
      any_cur_valid = 1'b0; any_right = 1'b0; hit_addr = '0;
      for (int i = 0; i < MAX_CHUNKS; i++) begin
         any_alloc     = any_alloc | stat[i].alloc_hit;
         any_split     = any_split | stat[i].split;
         any_rel       = any_rel | stat[i].rel_hit;
         any_merge     = any_merge | stat[i].can_merge;
         any_cur_valid = any_cur_valid | stat[i].cur_valid;
         any_right     = any_right | stat[i].right_valid;
         hit_addr      = hit_addr | stat[i].hit_addr;
         cur_vec[i]    = stat[i].cur;
      end
   end

   // cursor on the last cell: the walk ends there
   assign at_tail = cur_vec[MAX_CHUNKS-1];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (!heap_mode_ff) state_in = ST_FINISH;
               else if (in_kind == REQ_ALLOC) state_in = ST_ALLOC;
               else if (in_rel == '0) state_in = ST_FINISH;
               else state_in = ST_REL;
            end
         end
         ST_ALLOC: begin
            if (any_alloc || !any_cur_valid || at_tail) state_in = ST_FINISH;
         end
         ST_REL: begin
            if (any_rel) state_in = ST_MSTART;
            else if (!any_cur_valid || at_tail) state_in = ST_FINISH;
         end
         ST_MSTART: state_in = ST_MERGE;
         ST_MERGE: begin
            if (!any_merge && !any_right) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      cmd.op          = CELL_HOLD;
      cmd.size        = size_ff;
      cmd.split_ok    = (count_ff < CNT_W'(MAX_CHUNKS));
      cmd.split       = any_split;
      cmd.base        = region_base_ff;
      cmd.first_bytes = (region_bytes_ff >= HDR_ADDR) ? region_bytes_ff - HDR_ADDR : '0;
      cmd.rel_addr    = rel_ff;
      count_in      = count_ff;
      size_in       = size_ff;
      bump_in       = bump_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (csr_fire && csr_index == REG_HEAP_MODE && csr_data[0]) begin
               cmd.op   = CELL_INIT;
               count_in = CNT_W'(1);
            end
            if (csr_fire && csr_index == REG_BOOT_START) bump_in = boot_round;
            if (req_fire) begin
               size_in       = size_raw;
               res_addr_in   = '0;
               res_status_in = STATUS_DONE;
               if (in_kind == REQ_ALLOC) begin
                  if (!heap_mode_ff) begin
                     res_addr_in = bump_al;
                     bump_in     = bump_al + in_bytes;
                  end else begin
                     cmd.op = CELL_LOAD;
                  end
               end else if (!heap_mode_ff || in_rel == '0) begin
                  res_status_in = STATUS_IGNORED;
               end else begin
                  cmd.op = CELL_LOAD;
               end
            end
         end
         ST_ALLOC: begin
            if (any_alloc) begin
               cmd.op      = CELL_TAKE;
               res_addr_in = hit_addr;
               if (any_split) count_in = count_ff + CNT_W'(1);
            end else if (!any_cur_valid || at_tail) begin
               res_status_in = STATUS_OOM;
            end else begin
               cmd.op = CELL_STEP;
            end
         end
         ST_REL: begin
            if (any_rel) cmd.op = CELL_FREE;
            else if (!any_cur_valid || at_tail) res_status_in = STATUS_IGNORED;
            else cmd.op = CELL_STEP;
         end
         ST_MSTART: cmd.op = CELL_LOAD;
         ST_MERGE: begin
            if (any_merge) begin
               cmd.op   = CELL_MERGE;
               count_in = count_ff - CNT_W'(1);
            end else if (any_right) begin
               cmd.op = CELL_STEP;
            end
         end
         default: ;
      endcase
   end

   // chain of table cells
   for (genvar g = 0; g < MAX_CHUNKS; g++) begin : g_cell
      logic      l_mark, r_mark;
      entry_type l_pass, r_ent;
      if (g == 0) begin : g_head
         assign l_mark = 1'b1;
         assign l_pass = '0;
      end else begin : g_body
         assign l_mark = marks[g-1];
         assign l_pass = passes[g-1];
      end
      if (g == MAX_CHUNKS - 1) begin : g_tail
         assign r_mark = 1'b0;
         assign r_ent  = '0;
      end else begin : g_mid
         assign r_mark = marks[g+1];
         assign r_ent  = ents[g+1];
      end
      ffha_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .is_head    (g == 0),
         .cmd        (cmd),
         .left_mark  (l_mark),
         .left_pass  (l_pass),
         .right_mark (r_mark),
         .right_ent  (r_ent),
         .mark       (marks[g]),
         .ent        (ents[g]),
         .pass       (passes[g]),
         .stat       (stat[g])
      );
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         heap_mode_ff    <= 1'b0;
         region_base_ff  <= '0;
         region_bytes_ff <= '0;
         boot_start_ff   <= '0;
         bump_ff         <= '0;
         count_ff        <= CNT_W'(1);
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         bump_ff  <= bump_in;
         count_ff <= count_in;
         if (csr_fire) begin
            case (csr_index)
               REG_HEAP_MODE:    heap_mode_ff    <= csr_data[0];
               REG_REGION_BASE:  region_base_ff  <= csr_data;
               REG_REGION_BYTES: region_bytes_ff <= csr_data;
               REG_BOOT_START:   boot_start_ff   <= csr_data;
               default: ;
            endcase
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      size_ff       <= size_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      if (req_fire) rel_ff <= in_rel;
      if (rsp_load) begin
         rsp_addr_ff   <= res_addr_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_status_ff, rsp_addr_ff};

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_CHUNKS))
      else $error("chunk count out of range");
   a_one_cursor: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cur_vec))
      else $error("more than one cursor cell");
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("request transfer did not start work");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_status_ff == STATUS_DONE || rsp_status_ff == STATUS_OOM ||
                      rsp_status_ff == STATUS_IGNORED))
      else $error("bad status code");
   a_boot_start_tracked: assert property (@(posedge clock) disable iff (reset)
      (csr_fire && csr_index == REG_BOOT_START) |=> bump_ff[1:0] == 2'd0 &&
         boot_start_ff == $past(csr_data))
      else $error("bump pointer not reloaded");

endmodule
